// ===== design/rrlc_pkg.sv =====
// shared types and constants for the range rule line checker
`timescale 1ns / 1ps

package rrlc_pkg;

    localparam int CH_W    = 8;
    localparam int COUNT_W = 8;
    localparam int PHASE_W = 3;

    // rule phases
    localparam logic [PHASE_W-1:0] RP_FIRST    = 3'd0;
    localparam logic [PHASE_W-1:0] RP_VAL_OR_EQ = 3'd1;
    localparam logic [PHASE_W-1:0] RP_AFTER_VAL = 3'd2;
    localparam logic [PHASE_W-1:0] RP_RANGE_END = 3'd3;
    localparam logic [PHASE_W-1:0] RP_RIGHT_VAL = 3'd4;
    localparam logic [PHASE_W-1:0] RP_COMPLETE  = 3'd5;

    // token phases
    localparam logic [PHASE_W-1:0] TP_BETWEEN = 3'd0;
    localparam logic [PHASE_W-1:0] TP_MINUS   = 3'd1;
    localparam logic [PHASE_W-1:0] TP_DIGITS  = 3'd2;
    localparam logic [PHASE_W-1:0] TP_KEYWORD = 3'd3;
    localparam logic [PHASE_W-1:0] TP_AFTER_KW = 3'd4;

    localparam logic [PHASE_W-1:0] KW_LEN = 3'd4;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CH_W-1:0] CH_T     = 8'h74;

    localparam logic [CH_W-1:0] KW_TEXT [4] = '{8'h74, 8'h68, 8'h72, 8'h75};

    typedef struct packed {
        logic [PHASE_W-1:0] rule_phase;
        logic [PHASE_W-1:0] token_phase;
        logic [PHASE_W-1:0] keyword_pos;
        logic               error_seen;
        logic               line_done;
        logic [COUNT_W-1:0] value_count;
    } line_state_t;

    localparam line_state_t LINE_STATE_RESET = '{
        rule_phase:  RP_FIRST,
        token_phase: TP_BETWEEN,
        keyword_pos: '0,
        error_seen:  1'b0,
        line_done:   1'b0,
        value_count: '0
    };

    typedef struct packed {
        logic               valid;
        logic               status;
        logic [COUNT_W-1:0] count;
    } line_result_t;

endpackage

// ===== design/range_rule_line_checker_core.sv =====
// top level of the range rule line checker
// usage:
//   one character of a rule line enters per item on the s_ channel, tdata
//   carrying the character and tlast marking the final character of the line
//   a zero byte ends the line early; later characters up to tlast are ignored
//   one result item leaves on the m_ channel for each line, after its tlast item
//   m_tdata bit 0 is the status (0 ok, 1 syntax error), bits 8:1 the count
//   of left-side values and ranges, zero on error
// timing:
//   one item per cycle while s_tready is high; the line state register is updated in the
//   cycle of each accepted item and the result register is loaded at the same
//   edge, so a result appears in the cycle after its tlast item is accepted
// reset and stall:
//   aresetn low clears the line state and drops m_tvalid
//   while a result waits, s_tready follows m_tready, so a new item is still
//   taken in the cycle the waiting result leaves
`timescale 1ns / 1ps

module range_rule_line_checker_core
    import rrlc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CH_W-1:0]   s_tdata,   // ch
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata    // status, count, zero pad
);

    line_state_t  state_reg;
    line_state_t  state_next;
    line_result_t res;
    logic         s_fire;

    assign s_fire = s_tvalid && s_tready;

    rrlc_step u_step (
        .cur  (state_reg),
        .ch   (s_tdata),
        .last (s_tlast),
        .nxt  (state_next),
        .res  (res)
    );

    rrlc_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (s_fire),
        .res      (res),
        .in_ready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LINE_STATE_RESET;
        end else if (s_fire) begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/rrlc_step.sv =====
// next-state and line result logic for one character
`timescale 1ns / 1ps

module rrlc_step
    import rrlc_pkg::*;
(
    input  line_state_t         cur,
    input  logic [CH_W-1:0]     ch,
    input  logic                last,
    output line_state_t         nxt,
    output line_result_t        res
);

    line_state_t st;
    logic        fall;
    logic        is_dig;
    logic        is_blk;
    logic        is_sp_tab;
    logic        ok;

    function automatic line_state_t value_done(input line_state_t s);
        line_state_t r;
        r = s;
        r.token_phase = TP_BETWEEN;
        case (s.rule_phase)
            RP_FIRST, RP_VAL_OR_EQ: begin
                if (s.value_count != {COUNT_W{1'b1}}) begin
                    r.value_count = s.value_count + COUNT_W'(1);
                end
                r.rule_phase = RP_AFTER_VAL;
            end
            RP_RANGE_END: r.rule_phase = RP_VAL_OR_EQ;
            RP_RIGHT_VAL: r.rule_phase = RP_COMPLETE;
            default: ;
        endcase
        return r;
    endfunction

    function automatic line_state_t start_value(input line_state_t s, input logic [CH_W-1:0] c);
        line_state_t r;
        r = s;
        if (c == CH_MINUS) begin
            r.token_phase = TP_MINUS;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            r.token_phase = TP_DIGITS;
        end else begin
            r.error_seen = 1'b1;
        end
        return r;
    endfunction

    function automatic line_state_t finish(input line_state_t s);
        line_state_t r;
        r = s;
        if (!s.error_seen && s.token_phase == TP_DIGITS) begin
            r = value_done(s);
        end
        r.line_done = 1'b1;
        return r;
    endfunction

    assign is_dig    = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_sp_tab = (ch == CH_SPACE) || (ch == CH_TAB);
    assign is_blk    = is_sp_tab || (ch == CH_LF);

    always_comb begin
        st   = cur;
        fall = 1'b0;
        ok   = 1'b0;
        if (!cur.line_done) begin
            if (ch == CH_NUL) begin
                st = finish(cur);
            end else if (!cur.error_seen && cur.rule_phase != RP_COMPLETE) begin
                case (cur.token_phase)
                    TP_MINUS: begin
                        if (is_dig) begin
                            st.token_phase = TP_DIGITS;
                        end else begin
                            st.error_seen = 1'b1;
                        end
                    end
                    TP_DIGITS: begin
                        if (is_dig) begin
                            st = cur;
                        end else if (is_blk) begin
                            st = value_done(cur);
                        end else if (ch != CH_EQ) begin
                            st.error_seen = 1'b1;
                        end else begin
                            st = value_done(cur);
                            fall = (st.rule_phase != RP_COMPLETE);
                        end
                    end
                    TP_KEYWORD: begin
                        if (cur.keyword_pos < KW_LEN
                                && ch == KW_TEXT[cur.keyword_pos[1:0]]) begin
                            st.keyword_pos = cur.keyword_pos + 3'd1;
                            if (st.keyword_pos == KW_LEN) begin
                                st.token_phase = TP_AFTER_KW;
                            end
                        end else begin
                            st.error_seen = 1'b1;
                        end
                    end
                    TP_AFTER_KW: begin
                        if (is_sp_tab) begin
                            st.token_phase = TP_BETWEEN;
                            st.rule_phase  = RP_RANGE_END;
                        end else begin
                            st.error_seen = 1'b1;
                        end
                    end
                    default: fall = 1'b1;
                endcase

                if (fall && !is_blk) begin
                    case (st.rule_phase)
                        RP_AFTER_VAL: begin
                            if (ch == CH_T) begin
                                st.token_phase = TP_KEYWORD;
                                st.keyword_pos = 3'd1;
                            end else if (ch == CH_EQ) begin
                                st.rule_phase = RP_RIGHT_VAL;
                            end else begin
                                st.rule_phase = RP_VAL_OR_EQ;
                                st = start_value(st, ch);
                            end
                        end
                        RP_VAL_OR_EQ: begin
                            if (ch == CH_EQ) begin
                                st.rule_phase = RP_RIGHT_VAL;
                            end else begin
                                st = start_value(st, ch);
                            end
                        end
                        default: st = start_value(st, ch);
                    endcase
                end
            end
        end

        if (last && !st.line_done) begin
            st = finish(st);
        end
        ok = !st.error_seen && st.token_phase == TP_BETWEEN
             && (st.rule_phase == RP_COMPLETE || st.rule_phase == RP_FIRST);

        res.valid  = last;
        res.status = !ok;
        res.count  = ok ? st.value_count : '0;
        nxt        = last ? LINE_STATE_RESET : st;
    end

endmodule

// ===== design/rrlc_out.sv =====
// result register between the checker and the result channel
`timescale 1ns / 1ps

module rrlc_out
    import rrlc_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_fire,
    input  line_result_t  res,
    output logic          in_ready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [15:0]   m_tdata    // status, count, zero pad
);

    logic               valid_reg;
    logic               valid_next;
    logic               status_reg;
    logic [COUNT_W-1:0] count_reg;

    assign in_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (in_fire && res.valid) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_fire && res.valid) begin
            status_reg <= res.status;
            count_reg  <= res.count;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'd0, count_reg, status_reg};

endmodule

// ===== tb/tb_range_rule_line_checker_core.sv =====
// self-checking testbench for the range rule line checker core
`timescale 1ns / 1ps

module tb_range_rule_line_checker_core;
    import rrlc_pkg::*;

    localparam int  ITEM_TARGET  = 800;
    localparam int  SAT_VALUES   = 260;
    localparam int  CALM_TAIL    = 150;
    localparam int  CYCLE_LIMIT  = 300000;
    localparam int  DRAIN_CYCLES = 20;
    localparam logic [31:0] KW_WORD = "thru";

    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic            last;
    } char_item_t;

    typedef struct packed {
        logic               status;
        logic [COUNT_W-1:0] count;
    } line_verdict_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [CH_W-1:0]   s_tdata = '0;   // ch
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [15:0]       m_tdata;        // status, count, zero pad

    char_item_t        pending_chars[$];
    line_verdict_t     verdicts_due[$];
    logic [CH_W-1:0]   line_chars[$];
    line_state_t       rule_st = LINE_STATE_RESET;

    int fail_cnt   = 0;
    int chars_sent = 0;
    int lines_ok   = 0;
    int lines_bad  = 0;
    int cycle_cnt  = 0;
    int gap_left   = 0;
    int stall_left = 0;

    range_rule_line_checker_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // line syntax predictor

    function automatic logic is_blank_ch(input logic [CH_W-1:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF;
    endfunction

    function automatic logic is_digit_ch(input logic [CH_W-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function void end_of_value();
        rule_st.token_phase = TP_BETWEEN;
        case (rule_st.rule_phase)
            RP_FIRST, RP_VAL_OR_EQ: begin
                if (rule_st.value_count != {COUNT_W{1'b1}})
                    rule_st.value_count = rule_st.value_count + 1'b1;
                rule_st.rule_phase = RP_AFTER_VAL;
            end
            RP_RANGE_END: rule_st.rule_phase = RP_VAL_OR_EQ;
            RP_RIGHT_VAL: rule_st.rule_phase = RP_COMPLETE;
            default: ;
        endcase
    endfunction

    function void begin_value(input logic [CH_W-1:0] c);
        if (c == CH_MINUS)
            rule_st.token_phase = TP_MINUS;
        else if (is_digit_ch(c))
            rule_st.token_phase = TP_DIGITS;
        else
            rule_st.error_seen = 1'b1;
    endfunction

    function void take_char(input logic [CH_W-1:0] c);
        if (rule_st.rule_phase == RP_COMPLETE)
            return;
        case (rule_st.token_phase)
            TP_MINUS: begin
                if (is_digit_ch(c))
                    rule_st.token_phase = TP_DIGITS;
                else
                    rule_st.error_seen = 1'b1;
                return;
            end
            TP_DIGITS: begin
                if (is_digit_ch(c))
                    return;
                if (is_blank_ch(c)) begin
                    end_of_value();
                    return;
                end
                if (c != CH_EQ) begin
                    rule_st.error_seen = 1'b1;
                    return;
                end
                end_of_value();
                if (rule_st.rule_phase == RP_COMPLETE)
                    return;
            end
            TP_KEYWORD: begin
                if (rule_st.keyword_pos < KW_LEN &&
                    c == KW_WORD[31 - 8 * int'(rule_st.keyword_pos) -: 8]) begin
                    rule_st.keyword_pos = rule_st.keyword_pos + 1'b1;
                    if (rule_st.keyword_pos == KW_LEN)
                        rule_st.token_phase = TP_AFTER_KW;
                end else begin
                    rule_st.error_seen = 1'b1;
                end
                return;
            end
            TP_AFTER_KW: begin
                if (c == CH_SPACE || c == CH_TAB) begin
                    rule_st.token_phase = TP_BETWEEN;
                    rule_st.rule_phase  = RP_RANGE_END;
                end else begin
                    rule_st.error_seen = 1'b1;
                end
                return;
            end
            default: ;
        endcase

        if (is_blank_ch(c))
            return;
        case (rule_st.rule_phase)
            RP_AFTER_VAL: begin
                if (c == CH_T) begin
                    rule_st.token_phase = TP_KEYWORD;
                    rule_st.keyword_pos = 3'd1;
                    return;
                end
                rule_st.rule_phase = RP_VAL_OR_EQ;
                if (c == CH_EQ)
                    rule_st.rule_phase = RP_RIGHT_VAL;
                else
                    begin_value(c);
            end
            RP_VAL_OR_EQ: begin
                if (c == CH_EQ)
                    rule_st.rule_phase = RP_RIGHT_VAL;
                else
                    begin_value(c);
            end
            default: begin_value(c);
        endcase
    endfunction

    // a value still in its digits is closed by the line end
    function void end_line();
        if (!rule_st.error_seen && rule_st.token_phase == TP_DIGITS)
            end_of_value();
        rule_st.line_done = 1'b1;
    endfunction

    function void predict_char(input logic [CH_W-1:0] c, input logic last);
        logic          ok;
        line_verdict_t v;
        if (!rule_st.line_done) begin
            if (c == CH_NUL)
                end_line();
            else if (!rule_st.error_seen)
                take_char(c);
        end
        if (last) begin
            if (!rule_st.line_done)
                end_line();
            ok = !rule_st.error_seen && rule_st.token_phase == TP_BETWEEN &&
                 (rule_st.rule_phase == RP_COMPLETE || rule_st.rule_phase == RP_FIRST);
            v.status = !ok;
            v.count  = ok ? rule_st.value_count : '0;
            verdicts_due.push_back(v);
            rule_st = LINE_STATE_RESET;
        end
    endfunction

    // stimulus building

    task automatic push_item(input logic [CH_W-1:0] c, input logic last);
        char_item_t it;
        it.ch   = c;
        it.last = last;
        pending_chars.push_back(it);
    endtask

    task automatic send_text(input string s, input logic ends);
        for (int i = 0; i < s.len(); i++)
            push_item(s[i], ends && i == s.len() - 1);
    endtask

    task automatic put_blanks();
        int n;
        n = $urandom_range(1, 2);
        for (int i = 0; i < n; i++)
            case ($urandom_range(0, 2))
                0:       line_chars.push_back(CH_SPACE);
                1:       line_chars.push_back(CH_TAB);
                default: line_chars.push_back(CH_LF);
            endcase
    endtask

    task automatic put_number();
        int n;
        n = $urandom_range(1, 3);
        if ($urandom_range(0, 3) == 0)
            line_chars.push_back(CH_MINUS);
        for (int i = 0; i < n; i++)
            line_chars.push_back(CH_ZERO + CH_W'($urandom_range(0, 9)));
    endtask

    // well-formed rule with random content, sometimes broken afterwards
    task automatic make_rule_line();
        int n_left;
        int pos;
        n_left = $urandom_range(1, 4);
        line_chars.delete();
        if ($urandom_range(0, 4) == 0)
            put_blanks();
        for (int k = 0; k < n_left; k++) begin
            if (k > 0)
                put_blanks();
            put_number();
            if ($urandom_range(0, 2) == 0) begin
                put_blanks();
                for (int j = 0; j < 4; j++)
                    line_chars.push_back(KW_WORD[31 - 8 * j -: 8]);
                case ($urandom_range(0, 7))
                    0:       line_chars.push_back(CH_LF);
                    1, 2, 3: line_chars.push_back(CH_TAB);
                    default: line_chars.push_back(CH_SPACE);
                endcase
                if ($urandom_range(0, 3) == 0)
                    put_blanks();
                put_number();
            end
        end
        if ($urandom_range(0, 1) == 0)
            put_blanks();
        line_chars.push_back(CH_EQ);
        if ($urandom_range(0, 1) == 0)
            put_blanks();
        put_number();
        if ($urandom_range(0, 2) == 0) begin
            put_blanks();
            repeat ($urandom_range(1, 4))
                line_chars.push_back(CH_W'($urandom_range(0, 255)));
        end

        pos = $urandom_range(0, line_chars.size() - 1);
        case ($urandom_range(0, 9))
            0: line_chars[pos] = CH_W'($urandom_range(1, 255));
            1: line_chars[pos] = CH_NUL;
            2: while (line_chars.size() > pos + 1)
                   void'(line_chars.pop_back());
            3: case ($urandom_range(0, 4))
                   0:       line_chars[pos] = CH_T;
                   1:       line_chars[pos] = CH_EQ;
                   2:       line_chars[pos] = CH_MINUS;
                   3:       line_chars[pos] = CH_SPACE;
                   default: line_chars[pos] = 8'h72;
               endcase
            default: ;
        endcase
        for (int i = 0; i < line_chars.size(); i++)
            push_item(line_chars[i], i == line_chars.size() - 1);
    endtask

    task automatic make_noise_line();
        int n;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
            push_item(CH_W'($urandom_range(0, 255)), i == n - 1);
    endtask

    // input side

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_char(s_tdata, s_tlast);
                chars_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_chars.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (pending_chars.size() > CALM_TAIL &&
                             $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(0, 2);
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_chars[0].ch;
                    s_tlast  <= pending_chars[0].last;
                    void'(pending_chars.pop_front());
                end
            end
        end
    end

    // result side

    always @(posedge aclk) begin
        line_verdict_t v;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdicts_due.size() == 0) begin
                    $error("result item with no line pending: tdata %h", m_tdata);
                    fail_cnt++;
                end else begin
                    v = verdicts_due.pop_front();
                    if (m_tdata[0] !== v.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               v.status, m_tdata[0]);
                        fail_cnt++;
                    end
                    if (m_tdata[8:1] !== v.count) begin
                        $error("count mismatch: expected %0d, got %0d",
                               v.count, m_tdata[8:1]);
                        fail_cnt++;
                    end
                    if (m_tdata[15:9] !== '0) begin
                        $error("pad mismatch: expected 0, got %h", m_tdata[15:9]);
                        fail_cnt++;
                    end
                    if (v.status)
                        lines_bad++;
                    else
                        lines_ok++;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (pending_chars.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 2);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $error("timeout with %0d lines outstanding", verdicts_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        // empty and blank lines
        push_item(CH_NUL, 1'b1);
        send_text(" \t\n", 1'b1);
        send_text("5=7", 1'b1);
        send_text("-12 0 thru 99\t= -4 ignored", 1'b0);
        push_item(8'hFF, 1'b1);
        send_text("1 thru\t-9 thru 3 = 0", 1'b1);
        // zero byte cuts the line, rest is ignored
        send_text("3 = 4", 1'b0);
        push_item(CH_NUL, 1'b0);
        send_text("x=", 1'b1);
        send_text("1 thru\n2 = 3", 1'b1);
        send_text("1x = 2", 1'b1);
        send_text("1 thr 2 = 3", 1'b1);
        send_text("1 thru 5", 1'b1);
        send_text("1 = ", 1'b1);
        send_text("=", 1'b1);
        send_text("-", 1'b1);
        send_text("- 1 = 2", 1'b1);
        push_item(8'h80, 1'b1);
        send_text("8 9 = 1 ", 1'b0);
        push_item(8'hC3, 1'b1);
        // line split over a zero byte before any token
        push_item(CH_NUL, 1'b0);
        push_item(8'h7F, 1'b1);

        // left-side count saturates
        for (int i = 0; i < SAT_VALUES; i++)
            send_text("1 ", 1'b0);
        send_text("= 0", 1'b1);

        while (pending_chars.size() < ITEM_TARGET)
            if ($urandom_range(0, 9) == 0)
                make_noise_line();
            else
                make_rule_line();

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_chars.size() > 0 || s_tvalid || verdicts_due.size() > 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d characters; %0d lines judged well formed, %0d rejected",
                 chars_sent, lines_ok, lines_bad);
        if (fail_cnt == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
